>>> rtl/core/mctt_pkg.sv
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared types and constants for the MIDI clock tempo tracker.
// ----------------------------------------------------------------------------
package mctt_pkg;

    // ticks kept in the timestamp ring
    localparam int WINDOW     = 24;
    localparam int RING_AW    = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int RSUM_W     = RING_AW + 1;   // oldest + count before wrap

    // field widths
    localparam int CMD_W      = 3;
    localparam int TS_W       = 32;
    localparam int POS_W      = 14;
    localparam int TEMPO_W    = 24;
    localparam int TICKS_W    = 24;

    // stream word widths
    localparam int S_DATA_W   = 48;   // ts + pos, padded to bytes
    localparam int M_DATA_W   = 64;   // tempo + playing + locate + ticks, padded
    localparam int M_USER_W   = 1;

    // 2.5e6 bpm*us in 1/256 bpm units
    localparam int TEMPO_NUM_W = 30;
    localparam logic [TEMPO_NUM_W-1:0] TEMPO_NUM = 30'd640000000;
    localparam int PROD_W      = TEMPO_NUM_W + CNT_W;

    // numerator: TEMPO_NUM*(n-1) + span/2
    localparam longint unsigned NUM_MAX =
        longint'(640000000) * longint'(WINDOW - 1) + longint'(64'h7FFF_FFFF);
    localparam int NUM_W      = $clog2(NUM_MAX + 1);
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;
    localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_START    = 3'd1,
        CMD_CONTINUE = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_SONG_POS = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SPAN,
        S_DIV,
        S_EMIT
    } state_t;

    // divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/core/midi_clock_tempo_tracker.sv
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker
// MIDI beat clock tempo and transport tracker.
// ----------------------------------------------------------------------------
// One input word per transport event (s_axis), one output word per event
// (m_axis) showing the tracker state after that event.
// Input: tuser = cmd (tick, start, continue, stop, song position, clear all);
// tdata = tick timestamp in us and song position in sixteenths.
// A tick stores its timestamp in a 24-entry ring RAM and re-estimates the
// tempo as 640000000*(n-1)/span in 1/256 bpm (rounded, saturated), where
// span is newest minus oldest stored timestamp, mod 2^32.
// Non-tick events and a tick that finds the ring empty go straight to the
// emit step and the output register; a tick with zero span passes the RAM
// read and the span register, then emits with the tempo held. A tick that
// estimates passes the RAM read, the span register, then
// the bit-serial divider producing one quotient bit per cycle over NUM_W bits.
// One event in flight; tready is high only while idle, so a new event is
// taken only once the current one has left the emit step.
// A result sits in an output register; the next event is taken while it
// waits. If m_axis stalls, the following result holds in the emit step until
// the output register frees, and no input is taken meanwhile.
// Reset (and the clear-all command) zero tempo, transport and counters; the
// ring RAM is not cleared, only entries counted as written are ever used.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mctt_pkg::S_DATA_W-1:0]   s_axis_tdata,   // timestamp_us, song_position
    input  logic [mctt_pkg::CMD_W-1:0]      s_axis_tuser,   // cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mctt_pkg::M_DATA_W-1:0]   m_axis_tdata,   // tempo_bpm_q8, is_playing,
                                                            // locate_sixteenths,
                                                            // ticks_since_locate
    output logic [mctt_pkg::M_USER_W-1:0]   m_axis_tuser    // tempo_valid
);

    mctt_pkg::state_t                   state_reg, state_next;
    logic [mctt_pkg::CNT_W-1:0]         ring_count_reg, ring_count_next;
    logic [mctt_pkg::RING_AW-1:0]       ring_oldest_reg, ring_oldest_next;
    logic [mctt_pkg::TEMPO_W-1:0]       tempo_reg, tempo_next;
    logic                               playing_reg, playing_next;
    logic [mctt_pkg::POS_W-1:0]         locate_reg, locate_next;
    logic [mctt_pkg::TICKS_W-1:0]       ticks_reg, ticks_next;
    logic                               out_valid_reg, out_valid_next;

    // payload, no reset
    logic [mctt_pkg::TS_W-1:0]          ts_reg, ts_next;
    logic [mctt_pkg::NUM_W-1:0]         prod_reg, prod_next;
    logic [mctt_pkg::TS_W-1:0]          span_reg, span_next;
    logic [mctt_pkg::M_DATA_W-1:0]      out_data_reg, out_data_next;
    logic [mctt_pkg::M_USER_W-1:0]      out_user_reg, out_user_next;

    logic                               s_accept;
    mctt_pkg::cmd_t                     cmd;
    logic [mctt_pkg::TS_W-1:0]          in_ts;
    logic [mctt_pkg::POS_W-1:0]         in_pos;

    logic                               ram_we;
    logic [mctt_pkg::RING_AW-1:0]       ram_waddr;
    logic [mctt_pkg::RING_AW-1:0]       ram_raddr;
    logic [mctt_pkg::TS_W-1:0]          ram_rdata;

    logic                               div_start;
    logic [mctt_pkg::NUM_W-1:0]         div_num;
    mctt_pkg::div_stat_t                div_stat;
    logic [mctt_pkg::NUM_W-1:0]         div_quo;

    logic [mctt_pkg::RSUM_W-1:0]        wr_sum;
    logic [mctt_pkg::RSUM_W-1:0]        old_inc;
    logic [mctt_pkg::CNT_W-1:0]         nm1;
    logic [mctt_pkg::PROD_W-1:0]        prod_full;
    logic                               out_free;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == mctt_pkg::S_IDLE);
    assign cmd           = mctt_pkg::cmd_t'(s_axis_tuser);
    assign in_ts         = s_axis_tdata[mctt_pkg::TS_W-1:0];
    assign in_pos        = s_axis_tdata[mctt_pkg::TS_W +: mctt_pkg::POS_W];
    assign out_free      = !out_valid_reg || m_axis_tready;

    // ring addressing: append while filling, overwrite oldest once full
    assign wr_sum  = mctt_pkg::RSUM_W'(ring_oldest_reg) + mctt_pkg::RSUM_W'(ring_count_reg);
    assign old_inc = mctt_pkg::RSUM_W'(ring_oldest_reg) + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        ring_count_next  = ring_count_reg;
        ring_oldest_next = ring_oldest_reg;
        tempo_next       = tempo_reg;
        playing_next     = playing_reg;
        locate_next      = locate_reg;
        ticks_next       = ticks_reg;
        ts_next          = ts_reg;
        prod_next        = prod_reg;
        span_next        = span_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        ram_we           = 1'b0;
        ram_waddr        = ring_oldest_reg;
        ram_raddr        = ring_oldest_reg;
        div_start        = 1'b0;
        div_num          = prod_reg + mctt_pkg::NUM_W'(span_reg[mctt_pkg::TS_W-1:1]);
        nm1              = '0;
        prod_full        = '0;

        case (state_reg)
            mctt_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = mctt_pkg::S_EMIT;
                    case (cmd)
                        mctt_pkg::CMD_TICK:
                        begin
                            ram_we  = 1'b1;
                            ts_next = in_ts;
                            if (ring_count_reg < mctt_pkg::CNT_W'(mctt_pkg::WINDOW))
                            begin
                                if (wr_sum >= mctt_pkg::RSUM_W'(mctt_pkg::WINDOW))
                                begin
                                    ram_waddr = mctt_pkg::RING_AW'(wr_sum -
                                                mctt_pkg::RSUM_W'(mctt_pkg::WINDOW));
                                end
                                else
                                begin
                                    ram_waddr = mctt_pkg::RING_AW'(wr_sum);
                                end
                                ring_count_next = ring_count_reg + 1'b1;
                            end
                            else
                            begin
                                ram_waddr = ring_oldest_reg;
                                if (old_inc >= mctt_pkg::RSUM_W'(mctt_pkg::WINDOW))
                                begin
                                    ring_oldest_next = '0;
                                end
                                else
                                begin
                                    ring_oldest_next = mctt_pkg::RING_AW'(old_inc);
                                end
                            end
                            ram_raddr = ring_oldest_next;
                            if (ring_count_next >= mctt_pkg::CNT_W'(2))
                            begin
                                nm1        = ring_count_next - 1'b1;
                                prod_full  = mctt_pkg::TEMPO_NUM * nm1;
                                prod_next  = mctt_pkg::NUM_W'(prod_full);
                                state_next = mctt_pkg::S_READ;
                            end
                            if (playing_reg && (ticks_reg != mctt_pkg::TICKS_MAX))
                            begin
                                ticks_next = ticks_reg + 1'b1;
                            end
                        end
                        mctt_pkg::CMD_START:
                        begin
                            playing_next = 1'b1;
                            locate_next  = '0;
                            ticks_next   = '0;
                        end
                        mctt_pkg::CMD_CONTINUE:
                        begin
                            playing_next = 1'b1;
                        end
                        mctt_pkg::CMD_STOP:
                        begin
                            playing_next = 1'b0;
                        end
                        mctt_pkg::CMD_SONG_POS:
                        begin
                            locate_next = in_pos;
                            ticks_next  = '0;
                        end
                        mctt_pkg::CMD_CLEAR:
                        begin
                            ring_count_next  = '0;
                            ring_oldest_next = '0;
                            tempo_next       = '0;
                            playing_next     = 1'b0;
                            locate_next      = '0;
                            ticks_next       = '0;
                        end
                        default:
                        begin
                            // unused codes leave state untouched
                        end
                    endcase
                end
            end
            mctt_pkg::S_READ:
            begin
                // ram_rdata now holds the oldest timestamp
                span_next  = ts_reg - ram_rdata;
                state_next = mctt_pkg::S_SPAN;
            end
            mctt_pkg::S_SPAN:
            begin
                if (span_reg == '0)
                begin
                    state_next = mctt_pkg::S_EMIT;   // zero span: tempo held
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = mctt_pkg::S_DIV;
                end
            end
            mctt_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (|div_quo[mctt_pkg::NUM_W-1:mctt_pkg::TEMPO_W])
                    begin
                        tempo_next = mctt_pkg::TEMPO_MAX;
                    end
                    else
                    begin
                        tempo_next = div_quo[mctt_pkg::TEMPO_W-1:0];
                    end
                    state_next = mctt_pkg::S_EMIT;
                end
            end
            mctt_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, ticks_reg, locate_reg, playing_reg, tempo_reg};
                    out_user_next  = (tempo_reg != '0);
                    state_next     = mctt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mctt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mctt_pkg::S_IDLE;
            ring_count_reg  <= '0;
            ring_oldest_reg <= '0;
            tempo_reg       <= '0;
            playing_reg     <= 1'b0;
            locate_reg      <= '0;
            ticks_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ring_count_reg  <= ring_count_next;
            ring_oldest_reg <= ring_oldest_next;
            tempo_reg       <= tempo_next;
            playing_reg     <= playing_next;
            locate_reg      <= locate_next;
            ticks_reg       <= ticks_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg       <= ts_next;
        prod_reg     <= prod_next;
        span_reg     <= span_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    mctt_ram #(
        .WIDTH (mctt_pkg::TS_W),
        .DEPTH (mctt_pkg::WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_ts),
        .re    (s_accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mctt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (span_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_ring_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= mctt_pkg::CNT_W'(mctt_pkg::WINDOW))
        else $error("ring count exceeds window");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == mctt_pkg::S_DIV))
        else $error("divider finished outside divide step");

    a_tick_fills_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_axis_tuser == mctt_pkg::CMD_TICK)) |=> (ring_count_reg != '0))
        else $error("tick left ring empty");

    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[mctt_pkg::TEMPO_W-1:0] != '0)))
        else $error("tempo_valid does not match tempo");

endmodule

>>> rtl/core/mctt_ram.sv
// ----------------------------------------------------------------------------
// mctt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mctt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mctt_div.sv
// ----------------------------------------------------------------------------
// mctt_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mctt_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mctt_pkg::NUM_W-1:0]     num,
    input  logic [mctt_pkg::TS_W-1:0]      den,
    output mctt_pkg::div_stat_t            stat,
    output logic [mctt_pkg::NUM_W-1:0]     quo
);

    logic                              busy_reg, busy_next;
    logic [mctt_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [mctt_pkg::NUM_W-1:0]        quo_reg, quo_next;   // dividend in, quotient out
    logic [mctt_pkg::TS_W-1:0]         rem_reg, rem_next;
    logic [mctt_pkg::TS_W-1:0]         den_reg, den_next;

    logic [mctt_pkg::TS_W:0]           shifted;
    logic [mctt_pkg::TS_W+1:0]         diff;
    logic                              ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[mctt_pkg::NUM_W-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        ge        = ~diff[mctt_pkg::TS_W+1];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = mctt_pkg::DIV_CNT_W'(mctt_pkg::NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = ge ? diff[mctt_pkg::TS_W-1:0] : shifted[mctt_pkg::TS_W-1:0];
                quo_next = {quo_reg[mctt_pkg::NUM_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign quo       = quo_reg;

endmodule
